// ===== src/isingm_pkg.sv =====
// Shared types and constants for the Ising Metropolis spin-update core.
// Used by the front, queue, back and top modules; no dependencies.
package isingm_pkg;

  // Fixed field widths of the item and result channels
  localparam int SITE_W   = 5;
  localparam int RAND_W   = 32;
  localparam int THRESH_W = 32;
  localparam int DELTA_W  = 5;
  localparam int ENERGY_W = 13;
  localparam int MAGNET_W = 12;

  // Configuration register map
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH_4 = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH_8 = 1'd1;
  localparam logic [THRESH_W-1:0] THRESH_4_RESET = 32'd738927648;
  localparam logic [THRESH_W-1:0] THRESH_8_RESET = 32'd127126737;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_FLIP  = 1'b1
  } op_t;

  // One classified command, coordinates already reduced into the lattice
  typedef struct packed {
    op_t               op;
    logic              spin_value;
    logic [RAND_W-1:0] rand_word;
    logic [SITE_W-1:0] col;
    logic [SITE_W-1:0] row;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_C,
    ST_RD_L,
    ST_RD_R,
    ST_RD_U,
    ST_RD_D,
    ST_WB
  } back_state_t;

endpackage

// ===== src/isingm_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module isingm_ram #(
  parameter int DATA_W = 1,
  parameter int DEPTH  = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [DATA_W-1:0]        wdata,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // One access per cycle: write, or read into the output register
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/isingm_front.sv =====
// Front end: takes input items, folds the site into the lattice and classifies
// the operation. Depends on isingm_pkg.
module isingm_front #(
  parameter int LATTICE_WIDTH  = 32,
  parameter int LATTICE_HEIGHT = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_func,
  input  logic [isingm_pkg::SITE_W-1:0]    in_site_x,
  input  logic [isingm_pkg::SITE_W-1:0]    in_site_y,
  input  logic                             in_spin_value,
  input  logic [isingm_pkg::RAND_W-1:0]    in_rand_word,
  input  logic                             busy,
  input  logic                             q_full,
  output logic                             push_valid,
  output isingm_pkg::cmd_t                 push_data
);
  import isingm_pkg::*;

  // Compare-and-subtract steps needed to fold a site field into range
  localparam int COL_STEPS = ((2 ** SITE_W) - 1) / LATTICE_WIDTH;
  localparam int ROW_STEPS = ((2 ** SITE_W) - 1) / LATTICE_HEIGHT;

  logic              valid_r;
  cmd_t              cmd_r;
  logic [SITE_W-1:0] col_v;
  logic [SITE_W-1:0] row_v;
  logic              take_in;
  logic              push_done;

  // Fold column and row into the lattice
  always_comb begin
    col_v = in_site_x;
    for (int i = 0; i < COL_STEPS; i++) begin
      if (int'(col_v) >= LATTICE_WIDTH) begin
        col_v = col_v - SITE_W'(LATTICE_WIDTH);
      end
    end
    row_v = in_site_y;
    for (int i = 0; i < ROW_STEPS; i++) begin
      if (int'(row_v) >= LATTICE_HEIGHT) begin
        row_v = row_v - SITE_W'(LATTICE_HEIGHT);
      end
    end
  end

  assign in_stall  = busy || (valid_r && q_full);
  assign take_in   = in_valid && !in_stall;
  assign push_done = valid_r && !q_full;

  // Staging register ahead of the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take_in) begin
      valid_r <= 1'b1;
    end else if (push_done) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      cmd_r.op         <= in_func ? OP_FLIP : OP_WRITE;
      cmd_r.spin_value <= in_spin_value;
      cmd_r.rand_word  <= in_rand_word;
      cmd_r.col        <= col_v;
      cmd_r.row        <= row_v;
    end
  end

  assign push_valid = valid_r;
  assign push_data  = cmd_r;

endmodule

// ===== src/isingm_queue.sv =====
// Short command queue decoupling the front end from the update sequencer.
// Depends on isingm_pkg.
module isingm_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  input  isingm_pkg::cmd_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             pop_valid,
  output isingm_pkg::cmd_t pop_data
);
  import isingm_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && pop_valid;
  assign pop_data  = entry_r[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/isingm_back.sv =====
// Update sequencer: reads a site and its four neighbors from the spin RAM,
// decides the flip, writes back and keeps the totals. Depends on isingm_pkg
// and isingm_ram.
module isingm_back #(
  parameter int LATTICE_WIDTH  = 32,
  parameter int LATTICE_HEIGHT = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [isingm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [isingm_pkg::THRESH_W-1:0]      cfg_data,
  input  logic                                 q_valid,
  input  isingm_pkg::cmd_t                     q_data,
  output logic                                 q_pop,
  output logic                                 busy,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_accepted,
  output logic signed [isingm_pkg::DELTA_W-1:0]  out_delta_energy,
  output logic signed [isingm_pkg::ENERGY_W-1:0] out_energy_total,
  output logic signed [isingm_pkg::MAGNET_W-1:0] out_magnetization
);
  import isingm_pkg::*;

  localparam int SITES = LATTICE_WIDTH * LATTICE_HEIGHT;
  localparam int AW    = $clog2(SITES);
  localparam int XW    = $clog2(LATTICE_WIDTH);
  localparam int YW    = $clog2(LATTICE_HEIGHT);
  localparam int EW    = AW + 3;
  localparam int MW    = AW + 2;
  localparam logic signed [EW-1:0] ENERGY_RESET = EW'(-2 * SITES);
  localparam logic signed [MW-1:0] MAGNET_RESET = MW'(-SITES);
  localparam logic signed [MW-1:0] MAG_STEP_UP  = MW'(2);
  localparam logic signed [MW-1:0] MAG_STEP_DN  = MW'(-2);

  back_state_t         state_r, state_nxt;
  cmd_t                cmd_r;
  logic [AW-1:0]       clr_addr_r;
  logic                sc_r;
  logic [2:0]          nb_r;
  logic signed [EW-1:0] energy_r;
  logic signed [MW-1:0] magnet_r;
  logic [THRESH_W-1:0] thresh4_r;
  logic [THRESH_W-1:0] thresh8_r;
  logic                out_valid_r;
  logic                out_acc_r;
  logic signed [DELTA_W-1:0]  out_de_r;
  logic signed [ENERGY_W-1:0] out_e_r;
  logic signed [MAGNET_W-1:0] out_m_r;

  logic                ram_en;
  logic                ram_we;
  logic [AW-1:0]       ram_addr;
  logic [0:0]          ram_wdata;
  logic [0:0]          ram_rdata;

  logic [XW-1:0]       col_c, col_l, col_r, sel_col;
  logic [YW-1:0]       row_c, row_u, row_d, sel_row;
  logic                out_free;
  logic                wb_go;
  logic                clr_last;
  logic [2:0]          ones;
  logic signed [DELTA_W-1:0] nsum2;
  logic signed [DELTA_W-1:0] de;
  logic                take;
  logic signed [EW-1:0] energy_nxt;
  logic signed [MW-1:0] magnet_nxt;
  logic signed [31:0]  energy_ext;
  logic signed [31:0]  magnet_ext;

  isingm_ram #(
    .DATA_W (1),
    .DEPTH  (SITES)
  ) u_spin_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Wrapped neighbor coordinates
  assign col_c = XW'(cmd_r.col);
  assign row_c = YW'(cmd_r.row);
  assign col_l = (col_c == '0) ? XW'(LATTICE_WIDTH - 1) : col_c - XW'(1);
  assign col_r = (col_c == XW'(LATTICE_WIDTH - 1)) ? '0 : col_c + XW'(1);
  assign row_u = (row_c == '0) ? YW'(LATTICE_HEIGHT - 1) : row_c - YW'(1);
  assign row_d = (row_c == YW'(LATTICE_HEIGHT - 1)) ? '0 : row_c + YW'(1);

  always_comb begin
    sel_col = col_c;
    sel_row = row_c;
    case (state_r)
      ST_RD_L: sel_col = col_l;
      ST_RD_R: sel_col = col_r;
      ST_RD_U: sel_row = row_u;
      ST_RD_D: sel_row = row_d;
      default: begin
        sel_col = col_c;
        sel_row = row_c;
      end
    endcase
  end

  // Energy change from the site and its neighbors (down neighbor on the RAM port)
  always_comb begin
    ones  = 3'(nb_r[0]) + 3'(nb_r[1]) + 3'(nb_r[2]) + 3'(ram_rdata[0]);
    nsum2 = DELTA_W'({ones, 2'b00}) - DELTA_W'(8);
    de    = sc_r ? nsum2 : -nsum2;
    if (cmd_r.op == OP_WRITE) begin
      take = (cmd_r.spin_value != sc_r);
    end else if (de[DELTA_W-1] || de == '0) begin
      take = 1'b1;
    end else if (de == DELTA_W'(4)) begin
      take = cmd_r.rand_word < thresh4_r;
    end else begin
      take = cmd_r.rand_word < thresh8_r;
    end
    energy_nxt = take ? energy_r + EW'(de) : energy_r;
    magnet_nxt = !take ? magnet_r : (sc_r ? magnet_r + MAG_STEP_DN : magnet_r + MAG_STEP_UP);
    energy_ext = 32'(energy_nxt);
    magnet_ext = 32'(magnet_nxt);
  end

  assign out_free = !out_valid_r || !out_stall;
  assign clr_last = (clr_addr_r == AW'(SITES - 1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (q_valid) state_nxt = ST_RD_C;
      ST_RD_C:  state_nxt = ST_RD_L;
      ST_RD_L:  state_nxt = ST_RD_R;
      ST_RD_R:  state_nxt = ST_RD_U;
      ST_RD_U:  state_nxt = ST_RD_D;
      ST_RD_D:  state_nxt = ST_WB;
      ST_WB: begin
        if (out_free) begin
          state_nxt = q_valid ? ST_RD_C : ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // State outputs: RAM port, queue pop, write-back strobe
  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = AW'(sel_row) * AW'(LATTICE_WIDTH) + AW'(sel_col);
    ram_wdata = 1'b0;
    q_pop     = 1'b0;
    wb_go     = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = clr_addr_r;
      end
      ST_IDLE: q_pop = q_valid;
      ST_RD_C, ST_RD_L, ST_RD_R, ST_RD_U, ST_RD_D: ram_en = 1'b1;
      ST_WB: begin
        wb_go     = out_free;
        ram_en    = out_free && take;
        ram_we    = out_free && take;
        ram_wdata = ~sc_r;
        q_pop     = out_free && q_valid;
      end
      default: begin
        ram_en = 1'b0;
      end
    endcase
  end

  // Control state, totals and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      energy_r    <= ENERGY_RESET;
      magnet_r    <= MAGNET_RESET;
      thresh4_r   <= THRESH_4_RESET;
      thresh8_r   <= THRESH_8_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_THRESH_4: thresh4_r <= cfg_data;
          CFG_THRESH_8: thresh8_r <= cfg_data;
          default: begin
            thresh4_r <= thresh4_r;
          end
        endcase
      end
      if (wb_go) begin
        energy_r    <= energy_nxt;
        magnet_r    <= magnet_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Command latch, read captures and result register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_data;
    end
    case (state_r)
      ST_RD_L: sc_r     <= ram_rdata[0];
      ST_RD_R: nb_r[0]  <= ram_rdata[0];
      ST_RD_U: nb_r[1]  <= ram_rdata[0];
      ST_RD_D: nb_r[2]  <= ram_rdata[0];
      default: begin
        nb_r <= nb_r;
      end
    endcase
    if (wb_go) begin
      out_acc_r <= take;
      out_de_r  <= take ? de : '0;
      out_e_r   <= energy_ext[ENERGY_W-1:0];
      out_m_r   <= magnet_ext[MAGNET_W-1:0];
    end
  end

  assign busy              = (state_r == ST_CLEAR);
  assign out_valid         = out_valid_r;
  assign out_accepted      = out_acc_r;
  assign out_delta_energy  = out_de_r;
  assign out_energy_total  = out_e_r;
  assign out_magnetization = out_m_r;

endmodule

// ===== src/ising_metropolis_spin_update_core.sv =====
// Ising Metropolis spin-update core: front end, command queue, update sequencer.
// The single-port spin RAM serves one item at a time:
// five reads (site and four neighbors) and, if the update is taken, one write-back.
// The write-back waits while a held result is stalled at the output.
// After reset a clearing pass writes every site to spin -1, one site a cycle;
// input is stalled until it ends.
module ising_metropolis_spin_update_core #(
  parameter int LATTICE_WIDTH  = 32,
  parameter int LATTICE_HEIGHT = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [isingm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [isingm_pkg::THRESH_W-1:0]        cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_func,
  input  logic [isingm_pkg::SITE_W-1:0]          in_site_x,
  input  logic [isingm_pkg::SITE_W-1:0]          in_site_y,
  input  logic                                   in_spin_value,
  input  logic [isingm_pkg::RAND_W-1:0]          in_rand_word,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_accepted,
  output logic signed [isingm_pkg::DELTA_W-1:0]  out_delta_energy,
  output logic signed [isingm_pkg::ENERGY_W-1:0] out_energy_total,
  output logic signed [isingm_pkg::MAGNET_W-1:0] out_magnetization
);
  import isingm_pkg::*;

  logic busy;
  logic push_valid;
  cmd_t push_data;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cmd_t q_data;

  isingm_front #(
    .LATTICE_WIDTH  (LATTICE_WIDTH),
    .LATTICE_HEIGHT (LATTICE_HEIGHT)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_site_x     (in_site_x),
    .in_site_y     (in_site_y),
    .in_spin_value (in_spin_value),
    .in_rand_word  (in_rand_word),
    .busy          (busy),
    .q_full        (q_full),
    .push_valid    (push_valid),
    .push_data     (push_data)
  );

  isingm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_data)
  );

  isingm_back #(
    .LATTICE_WIDTH  (LATTICE_WIDTH),
    .LATTICE_HEIGHT (LATTICE_HEIGHT)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .q_valid           (q_valid),
    .q_data            (q_data),
    .q_pop             (q_pop),
    .busy              (busy),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_accepted      (out_accepted),
    .out_delta_energy  (out_delta_energy),
    .out_energy_total  (out_energy_total),
    .out_magnetization (out_magnetization)
  );

endmodule

// ===== bench/ising_metropolis_spin_update_core_tb.sv =====
// Self-checking bench for the Ising Metropolis spin-update core: a directed table, then
// random and sweep phases under several threshold settings, checked against a local lattice
// model. Depends on isingm_pkg and ising_metropolis_spin_update_core.
module ising_metropolis_spin_update_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import isingm_pkg::*;

  localparam int LAT_W = 32;
  localparam int LAT_H = 32;
  localparam int SITES = LAT_W * LAT_H;
  // cycles without any transfer; covers the clearing pass after reset plus long stalls
  localparam int IDLE_LIMIT = 6000;
  // a little over the idle latency of the core
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic                         accepted;
    logic signed [DELTA_W-1:0]    delta_energy;
    logic signed [ENERGY_W-1:0]   energy_total;
    logic signed [MAGNET_W-1:0]   magnetization;
  } spin_result_t;

  typedef struct {
    op_t                 op;
    logic [SITE_W-1:0]   x;
    logic [SITE_W-1:0]   y;
    logic                spin_value;
    logic [RAND_W-1:0]   rand_word;
    bit                  preset;        // expected result typed in below
    spin_result_t        preset_result;
  } update_item_t;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_THRESH_4;
  logic [THRESH_W-1:0]   cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_func = OP_WRITE;
  logic [SITE_W-1:0]     in_site_x = '0;
  logic [SITE_W-1:0]     in_site_y = '0;
  logic                  in_spin_value = 1'b0;
  logic [RAND_W-1:0]     in_rand_word = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_accepted;
  logic signed [DELTA_W-1:0]  out_delta_energy;
  logic signed [ENERGY_W-1:0] out_energy_total;
  logic signed [MAGNET_W-1:0] out_magnetization;

  ising_metropolis_spin_update_core #(
    .LATTICE_WIDTH (LAT_W),
    .LATTICE_HEIGHT(LAT_H)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_site_x        (in_site_x),
    .in_site_y        (in_site_y),
    .in_spin_value    (in_spin_value),
    .in_rand_word     (in_rand_word),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_accepted     (out_accepted),
    .out_delta_energy (out_delta_energy),
    .out_energy_total (out_energy_total),
    .out_magnetization(out_magnetization)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Lattice model state
  bit                 lattice [SITES];
  int                 energy_acc;
  int                 magnet_acc;
  logic [THRESH_W-1:0] thresh4_cur;
  logic [THRESH_W-1:0] thresh8_cur;

  spin_result_t       expected_q [$];
  int                 mismatch_count = 0;
  int                 idle_cycles = 0;
  int                 burst_left = 0;

  // Directed stimulus; preset rows start from the all-minus lattice with reset thresholds
  update_item_t directed_rows [15] = '{
    // all-minus lattice: flip costs +8, rand 0 always passes
    '{OP_FLIP,  5'd0,  5'd0,  1'b0, 32'h0000_0000, 1'b1,
      '{1'b1, 5'sd8, -13'sd2040, -12'sd1022}},
    // write of the value already held
    '{OP_WRITE, 5'd0,  5'd0,  1'b1, 32'hFFFF_FFFF, 1'b1,
      '{1'b0, 5'sd0, -13'sd2040, -12'sd1022}},
    '{OP_WRITE, 5'd0,  5'd0,  1'b0, 32'h0000_0000, 1'b1,
      '{1'b1, -5'sd8, -13'sd2048, -12'sd1024}},
    // corner site, largest rand word never passes
    '{OP_FLIP,  5'd31, 5'd31, 1'b1, 32'hFFFF_FFFF, 1'b1,
      '{1'b0, 5'sd0, -13'sd2048, -12'sd1024}},
    // rand equal to the +8 threshold is rejected, one below passes
    '{OP_FLIP,  5'd31, 5'd31, 1'b0, THRESH_8_RESET, 1'b1,
      '{1'b0, 5'sd0, -13'sd2048, -12'sd1024}},
    '{OP_FLIP,  5'd31, 5'd31, 1'b0, THRESH_8_RESET - 32'd1, 1'b1,
      '{1'b1, 5'sd8, -13'sd2040, -12'sd1022}},
    // +4 change through the wrapped left neighbor
    '{OP_FLIP,  5'd0,  5'd31, 1'b1, THRESH_4_RESET - 32'd1, 1'b0, '0},
    // +4 change through the wrapped upper neighbor, at and below the threshold
    '{OP_FLIP,  5'd31, 5'd0,  1'b0, THRESH_4_RESET, 1'b0, '0},
    '{OP_FLIP,  5'd31, 5'd0,  1'b1, THRESH_4_RESET - 32'd1, 1'b0, '0},
    // zero change is always taken, both directions
    '{OP_FLIP,  5'd31, 5'd31, 1'b0, 32'hFFFF_FFFF, 1'b0, '0},
    '{OP_FLIP,  5'd31, 5'd31, 1'b1, 32'hFFFF_FFFF, 1'b0, '0},
    // negative change is always taken
    '{OP_FLIP,  5'd0,  5'd31, 1'b0, 32'hFFFF_FFFF, 1'b0, '0},
    '{OP_WRITE, 5'd16, 5'd15, 1'b1, 32'hAAAA_5555, 1'b0, '0},
    '{OP_WRITE, 5'd15, 5'd16, 1'b0, 32'h5555_AAAA, 1'b0, '0},
    '{OP_FLIP,  5'd15, 5'd15, 1'b1, 32'h0000_0000, 1'b0, '0}
  };

  function automatic int spin_sign(int col, int row);
    return lattice[((row + LAT_H) % LAT_H) * LAT_W + ((col + LAT_W) % LAT_W)] ? 1 : -1;
  endfunction

  // Apply one item to the lattice model and return the result it should produce
  function automatic spin_result_t apply_update(update_item_t item);
    int col;
    int row;
    int site_idx;
    int s;
    int nsum;
    int de;
    bit take;
    spin_result_t r;
    col      = int'(item.x) % LAT_W;
    row      = int'(item.y) % LAT_H;
    site_idx = row * LAT_W + col;
    s        = spin_sign(col, row);
    nsum = spin_sign(col - 1, row) + spin_sign(col + 1, row) +
           spin_sign(col, row - 1) + spin_sign(col, row + 1);
    de   = 2 * s * nsum;
    if (item.op == OP_WRITE) begin
      take = (item.spin_value != lattice[site_idx]);
    end else if (de <= 0) begin
      take = 1'b1;
    end else if (de == 4) begin
      take = (item.rand_word < thresh4_cur);
    end else begin
      take = (item.rand_word < thresh8_cur);
    end
    if (take) begin
      lattice[site_idx] = ~lattice[site_idx];
      energy_acc += de;
      magnet_acc -= 2 * s;
    end else begin
      de = 0;
    end
    r.accepted      = take;
    r.delta_energy  = de[DELTA_W-1:0];
    r.energy_total  = energy_acc[ENERGY_W-1:0];
    r.magnetization = magnet_acc[MAGNET_W-1:0];
    return r;
  endfunction

  // Random item; rand words cluster around the live thresholds
  function automatic update_item_t random_update(int write_pct);
    update_item_t item;
    item.op         = ($urandom_range(0, 99) < write_pct) ? OP_WRITE : OP_FLIP;
    item.x          = SITE_W'($urandom_range(0, 31));
    item.y          = SITE_W'($urandom_range(0, 31));
    item.spin_value = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0, 1:    item.rand_word = thresh4_cur + $urandom_range(0, 4) - 32'd2;
      2, 3:    item.rand_word = thresh8_cur + $urandom_range(0, 4) - 32'd2;
      4:       item.rand_word = $urandom_range(0, 1) ? '1 : '0;
      default: item.rand_word = $urandom;
    endcase
    item.preset        = 1'b0;
    item.preset_result = '0;
    return item;
  endfunction

  // Offer one item, hold it until the transfer, then maybe open a gap
  task automatic send_update(input update_item_t item);
    spin_result_t predicted;
    in_valid      <= 1'b1;
    in_func       <= item.op;
    in_site_x     <= item.x;
    in_site_y     <= item.y;
    in_spin_value <= item.spin_value;
    in_rand_word  <= item.rand_word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_update(item);
    expected_q.push_back(item.preset ? item.preset_result : predicted);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 15);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Threshold writes only once the core has drained
  task automatic set_thresholds(input logic [THRESH_W-1:0] t4, input logic [THRESH_W-1:0] t8);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_THRESH_4;
    cfg_data  <= t4;
    @(posedge clk);
    cfg_index <= CFG_THRESH_8;
    cfg_data  <= t8;
    @(posedge clk);
    cfg_we <= 1'b0;
    thresh4_cur = t4;
    thresh8_cur = t8;
  endtask

  // Result receiver stall pattern, switching to a random mode after each run of random length
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;
  int          stall_phase = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    stall_phase++;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= ((stall_phase % 7) < 3);
    endcase
  end

  // Result checker and watchdog
  always @(posedge clk) begin
    spin_result_t want;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("result transfer with none pending: acc=%0d dE=%0d E=%0d M=%0d",
                     out_accepted, out_delta_energy, out_energy_total, out_magnetization);
        end else begin
          want = expected_q.pop_front();
          if (out_accepted !== want.accepted || out_delta_energy !== want.delta_energy ||
              out_energy_total !== want.energy_total ||
              out_magnetization !== want.magnetization) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display({"result mismatch: exp acc=%0d dE=%0d E=%0d M=%0d, ",
                        "got acc=%0d dE=%0d E=%0d M=%0d"},
                       want.accepted, want.delta_energy, want.energy_total, want.magnetization,
                       out_accepted, out_delta_energy, out_energy_total, out_magnetization);
          end
        end
      end
    end
  end

  // Main sequence
  initial begin
    update_item_t item;
    foreach (lattice[i]) lattice[i] = 1'b0;
    energy_acc  = -2 * SITES;
    magnet_acc  = -SITES;
    thresh4_cur = THRESH_4_RESET;
    thresh8_cur = THRESH_8_RESET;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) send_update(directed_rows[i]);

    // random mixes under extreme and random thresholds
    set_thresholds('0, '0);
    repeat (80) send_update(random_update(50));
    set_thresholds('1, '1);
    repeat (80) send_update(random_update(30));
    set_thresholds('1, '0);
    repeat (80) send_update(random_update(40));
    set_thresholds($urandom, $urandom);
    repeat (80) send_update(random_update(20));

    // sweep to all plus, then to a checkerboard: magnetization and energy extremes
    set_thresholds(THRESH_4_RESET, THRESH_8_RESET);
    for (int y = 0; y < LAT_H; y++) begin
      for (int x = 0; x < LAT_W; x++) begin
        item = random_update(100);
        item.x = x[SITE_W-1:0];
        item.y = y[SITE_W-1:0];
        item.spin_value = 1'b1;
        send_update(item);
      end
    end
    for (int y = 0; y < LAT_H; y++) begin
      for (int x = 0; x < LAT_W; x++) begin
        if (((x + y) % 2) == 1) begin
          item = random_update(100);
          item.x = x[SITE_W-1:0];
          item.y = y[SITE_W-1:0];
          item.spin_value = 1'b0;
          send_update(item);
        end
      end
    end

    // flip-heavy relaxation from the checkerboard
    set_thresholds($urandom, $urandom);
    repeat (100) send_update(random_update(10));

    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
